>>> hw/rtl/kocc_pkg.sv
// Package for the kanji output code converter.
// Holds code constants, item kinds and the pair conversion functions.
// No dependencies.
package kocc_pkg;

    localparam logic       CODE_IN_EUC  = 1'b0;
    localparam logic       CODE_IN_SJIS = 1'b1;

    localparam logic [1:0] CODE_EUC     = 2'd0;
    localparam logic [1:0] CODE_SJIS    = 2'd1;
    localparam logic [1:0] CODE_JIS     = 2'd2;

    localparam logic [1:0] KIND_SINGLE  = 2'd0;
    localparam logic [1:0] KIND_DOUBLE  = 2'd1;
    localparam logic [1:0] KIND_ESCAPE  = 2'd2;

    localparam logic       CFG_INTERNAL = 1'b0;
    localparam logic       CFG_OUTPUT   = 1'b1;

    localparam logic [7:0] ESC_BYTE     = 8'h1b;
    localparam logic [7:0] ESC_KANJI    = 8'h24;
    localparam logic [7:0] ESC_ASCII    = 8'h28;
    localparam logic [7:0] ESC_FINAL    = 8'h42;

    localparam int         MAX_RESULTS  = 5;
    localparam int         CNT_W        = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] lo;
    } t_pair;

    function automatic logic starts_pair(input logic internal_code, input logic [7:0] c);
        if (internal_code == CODE_IN_EUC) begin
            return c[7];
        end
        return ((c >= 8'h81) && (c <= 8'h9f)) || ((c >= 8'he0) && (c <= 8'hfc));
    endfunction

    function automatic t_pair euc_to_sjis(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] h;
        logic [6:0] l;
        logic [7:0] half;
        logic [7:0] ofs;
        t_pair      r;
        h    = a[6:0];
        l    = b[6:0];
        // row zero: halving floors to -1
        half = (h == 7'd0) ? 8'hff : {2'b00, h[6:1] - {5'd0, ~h[0]}};
        r.hi = half + ((h <= 7'h5e) ? 8'h71 : 8'hb1);
        if (h[0]) begin
            ofs = (l < 7'h60) ? 8'h1f : 8'h20;
        end else begin
            ofs = 8'h7e;
        end
        r.lo = {1'b0, l} + ofs;
        return r;
    endfunction

    function automatic t_pair sjis_to_euc(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] h;
        logic [7:0] l;
        t_pair      r;
        h = {a[6:0], 1'b0} - ((a <= 8'h9f) ? 8'he1 : 8'h61);
        if (b < 8'h9f) begin
            l = b - ((b > 8'h7f) ? 8'h20 : 8'h1f);
        end else begin
            l = b - 8'h7e;
            h = h + 8'd1;
        end
        r.hi = h | 8'h80;
        r.lo = l | 8'h80;
        return r;
    endfunction

endpackage

>>> hw/rtl/kanji_output_code_converter_core.sv
// Kanji output code converter, top level.
// Uses kocc_pkg for code constants and pair conversion functions.
//
//  channel   dir  handshake                         payload
//  ------    ---  --------------------------------  -----------------------------------
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata[7:0] in_byte
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata out_byte, tuser kind, tlast
//  cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// An accepted item is converted in the same cycle and its 0 to 5 result bytes are
// loaded into a result buffer; one byte leaves per cycle on m_axis while i_m_axis_tready is high.
// A new item is taken when the buffer is empty or its last byte leaves that cycle.
// Synchronous active-low reset clears mode, pending lead, config and buffer count.
module kanji_output_code_converter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] byte_kind
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [1:0] i_cfg_data
);

    localparam int NR = kocc_pkg::MAX_RESULTS;
    localparam int CW = kocc_pkg::CNT_W;

    logic          r_internal_code;
    logic [1:0]    r_output_code;
    logic          r_lead_pending;
    logic [7:0]    r_lead_byte;
    logic          r_kanji_mode;
    logic [7:0]    r_buf_byte [NR];
    logic [1:0]    r_buf_kind [NR];
    logic [CW-1:0] r_cnt;

    logic          n_lead_pending;
    logic [7:0]    n_lead_byte;
    logic          n_kanji_mode;
    logic [7:0]    n_buf_byte [NR];
    logic [1:0]    n_buf_kind [NR];
    logic [CW-1:0] n_cnt;

    logic              in_acc;
    logic              out_acc;
    logic              is_jis;
    kocc_pkg::t_pair   conv;
    kocc_pkg::t_pair   p_e2s;
    kocc_pkg::t_pair   p_s2e;

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_buf_byte[0];
    assign o_m_axis_tuser  = r_buf_kind[0];
    assign o_m_axis_tlast  = (r_cnt == CW'(1));
    assign o_s_axis_tready = (r_cnt == '0) || ((r_cnt == CW'(1)) && i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign is_jis          = (r_output_code == kocc_pkg::CODE_JIS);

    assign p_e2s = kocc_pkg::euc_to_sjis(r_lead_byte, i_s_axis_tdata);
    assign p_s2e = kocc_pkg::sjis_to_euc(r_lead_byte, i_s_axis_tdata);

    always_comb begin
        conv.hi = r_lead_byte;
        conv.lo = i_s_axis_tdata;
        if ({1'b0, r_internal_code} == r_output_code) begin
            conv.hi = r_lead_byte;
        end else if (r_internal_code == kocc_pkg::CODE_IN_EUC) begin
            if (r_output_code == kocc_pkg::CODE_JIS) begin
                conv.hi = {1'b0, r_lead_byte[6:0]};
                conv.lo = {1'b0, i_s_axis_tdata[6:0]};
            end else if (r_output_code == kocc_pkg::CODE_SJIS) begin
                conv = p_e2s;
            end
        end else begin
            if (r_output_code == kocc_pkg::CODE_JIS) begin
                conv.hi = {1'b0, p_s2e.hi[6:0]};
                conv.lo = {1'b0, p_s2e.lo[6:0]};
            end else if (r_output_code == kocc_pkg::CODE_EUC) begin
                conv = p_s2e;
            end
        end
    end

    always_comb begin
        n_lead_pending = r_lead_pending;
        n_lead_byte    = r_lead_byte;
        n_kanji_mode   = r_kanji_mode;
        n_cnt          = r_cnt;
        for (int i = 0; i < NR; i++) begin
            n_buf_byte[i] = r_buf_byte[i];
            n_buf_kind[i] = r_buf_kind[i];
        end
        if (out_acc) begin
            for (int i = 0; i < NR - 1; i++) begin
                n_buf_byte[i] = r_buf_byte[i+1];
                n_buf_kind[i] = r_buf_kind[i+1];
            end
            n_cnt = r_cnt - CW'(1);
        end
        if (in_acc) begin
            n_cnt = '0;
            if (!r_lead_pending
                && kocc_pkg::starts_pair(r_internal_code, i_s_axis_tdata)) begin
                n_lead_byte    = i_s_axis_tdata;
                n_lead_pending = 1'b1;
            end else if (r_lead_pending) begin
                n_lead_pending = 1'b0;
                n_kanji_mode   = 1'b1;
                if (!r_kanji_mode && is_jis) begin
                    n_buf_byte[0] = kocc_pkg::ESC_BYTE;
                    n_buf_byte[1] = kocc_pkg::ESC_KANJI;
                    n_buf_byte[2] = kocc_pkg::ESC_FINAL;
                    n_buf_byte[3] = conv.hi;
                    n_buf_byte[4] = conv.lo;
                    n_buf_kind[0] = kocc_pkg::KIND_ESCAPE;
                    n_buf_kind[1] = kocc_pkg::KIND_ESCAPE;
                    n_buf_kind[2] = kocc_pkg::KIND_ESCAPE;
                    n_buf_kind[3] = kocc_pkg::KIND_DOUBLE;
                    n_buf_kind[4] = kocc_pkg::KIND_DOUBLE;
                    n_cnt         = CW'(5);
                end else begin
                    n_buf_byte[0] = conv.hi;
                    n_buf_byte[1] = conv.lo;
                    n_buf_kind[0] = kocc_pkg::KIND_DOUBLE;
                    n_buf_kind[1] = kocc_pkg::KIND_DOUBLE;
                    n_cnt         = CW'(2);
                end
            end else begin
                n_kanji_mode = 1'b0;
                if (r_kanji_mode && is_jis) begin
                    n_buf_byte[0] = kocc_pkg::ESC_BYTE;
                    n_buf_byte[1] = kocc_pkg::ESC_ASCII;
                    n_buf_byte[2] = kocc_pkg::ESC_FINAL;
                    n_buf_byte[3] = i_s_axis_tdata;
                    n_buf_kind[0] = kocc_pkg::KIND_ESCAPE;
                    n_buf_kind[1] = kocc_pkg::KIND_ESCAPE;
                    n_buf_kind[2] = kocc_pkg::KIND_ESCAPE;
                    n_buf_kind[3] = kocc_pkg::KIND_SINGLE;
                    n_cnt = (i_s_axis_tdata != 8'd0) ? CW'(4) : CW'(3);
                end else begin
                    n_buf_byte[0] = i_s_axis_tdata;
                    n_buf_kind[0] = kocc_pkg::KIND_SINGLE;
                    n_cnt = (i_s_axis_tdata != 8'd0) ? CW'(1) : CW'(0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_lead_byte    <= 8'd0;
            r_kanji_mode   <= 1'b0;
            r_cnt          <= '0;
        end else begin
            r_lead_pending <= n_lead_pending;
            r_lead_byte    <= n_lead_byte;
            r_kanji_mode   <= n_kanji_mode;
            r_cnt          <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NR; i++) begin
            r_buf_byte[i] <= n_buf_byte[i];
            r_buf_kind[i] <= n_buf_kind[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_internal_code <= 1'b0;
            r_output_code   <= 2'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kocc_pkg::CFG_INTERNAL: r_internal_code <= i_cfg_data[0];
                kocc_pkg::CFG_OUTPUT:   r_output_code   <= i_cfg_data;
                default:                r_output_code   <= r_output_code;
            endcase
        end
    end

endmodule
